[src/u8d_pkg.sv]
// Package with shared types, constants and helpers of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAw     = $clog2(QDepth);

  typedef enum logic [2:0] {
    ErrOk       = 3'd0,
    ErrBadLead  = 3'd1,
    ErrBadCont  = 3'd2,
    ErrOverlong = 3'd3,
    ErrTooLarge = 3'd4,
    ErrSurrogate = 3'd5,
    ErrTruncated = 3'd6
  } err_e;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    err_e               err;
  } res_t;

  // Results caused by one input word: up to two, cnt says how many.
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Append one result to an entry; the code point is zeroed on error.
  function automatic entry_t emit(entry_t e, logic [CpWidth-1:0] cp, err_e err);
    entry_t o;
    res_t   r;
    o      = e;
    r.cp   = (err == ErrOk) ? cp : '0;
    r.err  = err;
    if (e.cnt == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.cnt = e.cnt + 2'd1;
    return o;
  endfunction

  // Final range checks on a completed multi-byte sequence.
  function automatic err_e check_value(logic [CpWidth-1:0] v, logic [1:0] len);
    logic [CpWidth-1:0] minimum;
    err_e               e;
    unique case (len)
      2'd1:    minimum = 21'h00080;
      2'd2:    minimum = 21'h00800;
      default: minimum = 21'h10000;
    endcase
    if (v < minimum) begin
      e = ErrOverlong;
    end else if (v > 21'h10FFFF) begin
      e = ErrTooLarge;
    end else if (v >= 21'h00D800 && v <= 21'h00DFFF) begin
      e = ErrSurrogate;
    end else begin
      e = ErrOk;
    end
    return e;
  endfunction

endpackage

[src/u8d_front.sv]
// Front end: holds the sequence state and classifies each input word into results.
`timescale 1ns / 1ps

module u8d_front
  import u8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output entry_t     push_entry_o
);

  logic [CpWidth-1:0] pv_q, pv_d;
  logic [1:0]         rem_q, rem_d;
  logic [1:0]         len_q, len_d;
  logic               accept;
  entry_t             e;
  logic               as_lead;
  logic [CpWidth-1:0] pv_n;
  logic [1:0]         rem_n;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    e       = '0;
    as_lead = 1'b1;
    pv_d    = pv_q;
    rem_d   = rem_q;
    len_d   = len_q;
    pv_n    = {pv_q[CpWidth-7:0], data_byte_i[5:0]};
    rem_n   = rem_q - 2'd1;

    if (rem_q != 2'd0) begin
      if (data_byte_i[7:6] == 2'b10) begin
        as_lead = 1'b0;
        pv_d    = pv_n;
        rem_d   = rem_n;
        if (rem_n == 2'd0) begin
          e     = emit(e, pv_n, check_value(pv_n, len_q));
          pv_d  = '0;
          len_d = 2'd0;
        end else if (end_of_data_i) begin
          e     = emit(e, '0, ErrTruncated);
          pv_d  = '0;
          rem_d = 2'd0;
          len_d = 2'd0;
        end
      end else begin
        // Drop the open sequence; the word is read again as a lead.
        e     = emit(e, '0, ErrBadCont);
        pv_d  = '0;
        rem_d = 2'd0;
        len_d = 2'd0;
      end
    end

    if (as_lead) begin
      if (data_byte_i[7] == 1'b0) begin
        e = emit(e, CpWidth'(data_byte_i), ErrOk);
      end else if (data_byte_i[7:5] == 3'b110) begin
        pv_d  = CpWidth'(data_byte_i[4:0]);
        rem_d = 2'd1;
        len_d = 2'd1;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        pv_d  = CpWidth'(data_byte_i[3:0]);
        rem_d = 2'd2;
        len_d = 2'd2;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        pv_d  = CpWidth'(data_byte_i[2:0]);
        rem_d = 2'd3;
        len_d = 2'd3;
      end else begin
        e = emit(e, '0, ErrBadLead);
      end
      if (rem_d != 2'd0 && end_of_data_i) begin
        e     = emit(e, '0, ErrTruncated);
        pv_d  = '0;
        rem_d = 2'd0;
        len_d = 2'd0;
      end
    end
  end

  assign push_o       = accept && (e.cnt != 2'd0);
  assign push_entry_o = e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      rem_q <= 2'd0;
      len_q <= 2'd0;
    end else if (accept) begin
      pv_q  <= pv_d;
      rem_q <= rem_d;
      len_q <= len_d;
    end
  end

endmodule

[src/u8d_queue.sv]
// Short queue of result entries between the front and back ends.
`timescale 1ns / 1ps

module u8d_queue
  import u8d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    push_entry_i,
  input  logic      pop_i,
  output entry_t    head_o,
  output q_status_t status_o
);

  entry_t         mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;
  logic           do_push, do_pop;

  assign status_o.full      = (cnt_q == (QAw+1)'(QDepth));
  assign status_o.not_empty = (cnt_q != '0);
  assign head_o             = mem_q[rd_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.not_empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QAw+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QAw+1)'(1);
      end
    end
  end

endmodule

[src/u8d_back.sv]
// Back end: output register that hands out the results of each entry one word at a time.
`timescale 1ns / 1ps

module u8d_back
  import u8d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_status_t          q_status_i,
  input  entry_t             head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CpWidth-1:0] code_point_o,
  output logic [2:0]         error_kind_o,
  output logic               last_of_run_o
);

  entry_t cur_q;
  logic   idx_q;
  logic   valid_q;
  logic   last;
  logic   take;
  res_t   r;

  assign last = idx_q || (cur_q.cnt == 2'd1);
  assign take = valid_q && !out_stall_i;
  assign pop_o = q_status_i.not_empty && (!valid_q || (take && last));

  assign r             = idx_q ? cur_q.r1 : cur_q.r0;
  assign out_valid_o   = valid_q;
  assign code_point_o  = r.cp;
  assign error_kind_o  = r.err;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (take) begin
      // Advance to the second result, or go empty after the last.
      if (!last) begin
        idx_q <= 1'b1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

[src/utf8_stream_decoder_top.sv]
// Top level of the strict streaming UTF-8 decoder.
`timescale 1ns / 1ps

// Strict UTF-8 decoder: one byte word is accepted per cycle while the
// four-entry result queue has room. Each byte gives zero, one or two result
// words (a bad continuation is followed by any result of the same byte read
// as a lead); last_of_run_o marks the final result of a byte. Results leave
// through an output register at one word per cycle while out_stall_i is low;
// each result passes through the queue and then the output register after
// the edge that accepts its byte. code_point_o is zero whenever
// error_kind_o is nonzero.
module utf8_stream_decoder_top
  import u8d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CpWidth-1:0] code_point_o,
  output logic [2:0]         error_kind_o,
  output logic               last_of_run_o
);

  q_status_t q_status;
  logic      push;
  entry_t    push_entry;
  logic      pop;
  entry_t    head;

  u8d_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .end_of_data_i,
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  u8d_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  u8d_back u_back (
    .clk_i,
    .rst_ni,
    .q_status_i   (q_status),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .code_point_o,
    .error_kind_o,
    .last_of_run_o
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the strict streaming UTF-8 decoder.
`timescale 1ns / 1ps

module tb_top;
  import u8d_pkg::*;

  localparam int unsigned RandomWords = 1850;
  localparam int unsigned Phases      = 4;
  localparam int unsigned DrainCycles = 10;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    err_e               err;
    logic               last;
  } cp_result_t;

  // One byte word; where typed is set, the results are given in the row itself.
  typedef struct packed {
    logic [7:0]         b;
    logic               eod;
    logic               typed;
    logic [1:0]         n;
    logic [CpWidth-1:0] cp0;
    err_e               e0;
    logic [CpWidth-1:0] cp1;
    err_e               e1;
  } word_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte   = 8'h00;
  logic               end_of_data = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [CpWidth-1:0] code_point;
  logic [2:0]         error_kind;
  logic               last_of_run;

  word_t      cur_word = '0;
  word_t      stim_q[$];
  cp_result_t pending_cps[$];

  int send_idle     = 0;
  int recv_stall    = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int error_results = 0;
  int fail_count    = 0;

  // Decoder state as the predictor sees it
  logic [CpWidth-1:0] acc       = '0;
  logic [1:0]         cont_left = 2'd0;
  logic [1:0]         seq_len   = 2'd0;
  cp_result_t         step_res[2];
  int                 step_cnt;

  utf8_stream_decoder_top DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .end_of_data_i(end_of_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .code_point_o (code_point),
    .error_kind_o (error_kind),
    .last_of_run_o(last_of_run)
  );

  always #2 clk = ~clk;

  function automatic void add_result(logic [CpWidth-1:0] cp, err_e err);
    step_res[step_cnt].cp   = (err == ErrOk) ? cp : {CpWidth{1'b0}};
    step_res[step_cnt].err  = err;
    step_res[step_cnt].last = 1'b0;
    step_cnt++;
  endfunction

  function automatic void drop_sequence();
    acc       = '0;
    cont_left = 2'd0;
    seq_len   = 2'd0;
  endfunction

  // Advance the predicted decoder by one byte and collect its results.
  function automatic void decode_byte(logic [7:0] b, logic eod);
    logic               as_lead;
    logic [CpWidth-1:0] minimum;
    err_e               verdict;
    as_lead  = 1'b1;
    step_cnt = 0;
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        as_lead   = 1'b0;
        acc       = {acc[CpWidth-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          minimum = (seq_len == 2'd1) ? 21'h00080 :
                    (seq_len == 2'd2) ? 21'h00800 : 21'h10000;
          if (acc < minimum) begin
            verdict = ErrOverlong;
          end else if (acc > 21'h10FFFF) begin
            verdict = ErrTooLarge;
          end else if (acc >= 21'h00D800 && acc <= 21'h00DFFF) begin
            verdict = ErrSurrogate;
          end else begin
            verdict = ErrOk;
          end
          add_result(acc, verdict);
          drop_sequence();
        end else if (eod) begin
          add_result('0, ErrTruncated);
          drop_sequence();
        end
      end else begin
        // broken sequence: report it, then read the same byte as a lead
        add_result('0, ErrBadCont);
        drop_sequence();
      end
    end
    if (as_lead) begin
      if (!b[7]) begin
        add_result({13'd0, b}, ErrOk);
      end else if (b[7:5] == 3'b110) begin
        acc = {16'd0, b[4:0]}; cont_left = 2'd1; seq_len = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc = {17'd0, b[3:0]}; cont_left = 2'd2; seq_len = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc = {18'd0, b[2:0]}; cont_left = 2'd3; seq_len = 2'd3;
      end else begin
        add_result('0, ErrBadLead);
      end
      if (cont_left != 2'd0 && eod) begin
        add_result('0, ErrTruncated);
        drop_sequence();
      end
    end
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    word_t w;
    w     = '0;
    w.b   = b;
    w.eod = ($urandom_range(99) < 4);
    stim_q.push_back(w);
  endfunction

  function automatic logic [7:0] cont_byte(logic [5:0] bits);
    return {2'b10, bits};
  endfunction

  // Mostly well-formed scalars, also loose sequences that hit the range
  // checks and raw noise.
  function automatic void add_sequence();
    int          kind;
    int          len;
    logic [20:0] cp;
    logic [7:0]  lead;
    kind = int'($urandom_range(99));
    if (kind < 60) begin
      len = int'($urandom_range(1, 4));
      case (len)
        1: cp = 21'($urandom_range(21'h7F, 0));
        2: cp = 21'($urandom_range(21'h7FF, 21'h80));
        3: begin
          cp = 21'($urandom_range(21'hFFFF, 21'h800));
          while (cp >= 21'hD800 && cp <= 21'hDFFF) begin
            cp = 21'($urandom_range(21'hFFFF, 21'h800));
          end
        end
        default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      endcase
      case (len)
        1: push_byte({1'b0, cp[6:0]});
        2: begin
          push_byte({3'b110, cp[10:6]});
          push_byte(cont_byte(cp[5:0]));
        end
        3: begin
          push_byte({4'b1110, cp[15:12]});
          push_byte(cont_byte(cp[11:6]));
          push_byte(cont_byte(cp[5:0]));
        end
        default: begin
          push_byte({5'b11110, cp[20:18]});
          push_byte(cont_byte(cp[17:12]));
          push_byte(cont_byte(cp[11:6]));
          push_byte(cont_byte(cp[5:0]));
        end
      endcase
    end else if (kind < 85) begin
      lead = 8'($urandom_range(8'hF7, 8'hC0));
      len  = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
      push_byte(lead);
      repeat (len) push_byte(cont_byte(6'($urandom_range(63, 0))));
    end else begin
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255, 0)));
    end
  endfunction

  task automatic send_word(input word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= w.b;
    end_of_data <= w.eod;
    cur_word    <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    cp_result_t got;
    cp_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_byte(cur_word.b, cur_word.eod);
        if (cur_word.typed) begin
          step_cnt    = int'(cur_word.n);
          step_res[0] = '{cp: cur_word.cp0, err: cur_word.e0, last: (cur_word.n == 2'd1)};
          step_res[1] = '{cp: cur_word.cp1, err: cur_word.e1, last: 1'b1};
        end
        for (int i = 0; i < step_cnt; i++) pending_cps.push_back(step_res[i]);
        words_sent++;
      end
      if (out_valid && !out_stall) begin
        got = '{cp: code_point, err: err_e'(error_kind), last: last_of_run};
        results_seen++;
        if (pending_cps.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result cp=%h err=%0d last=%0d",
                   $time, got.cp, got.err, got.last);
        end else begin
          want = pending_cps.pop_front();
          if (want.err != ErrOk) error_results++;
          if (got.cp !== want.cp || got.err !== want.err || got.last !== want.last) begin
            fail_count++;
            $display("%0t: mismatch expected cp=%h err=%0d last=%0d, got cp=%h err=%0d last=%0d",
                     $time, want.cp, want.err, want.last, got.cp, got.err, got.last);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    word_t dir_rows [27];
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 2'd1, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h7F, 1'b0, 1'b1, 2'd1, 21'h0007F, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b1, 2'd1, 21'h00000, ErrBadLead,   21'h0, ErrOk},
      '{8'hFF, 1'b0, 1'b1, 2'd1, 21'h00000, ErrBadLead,   21'h0, ErrOk},
      '{8'hC2, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      // overlong two-byte and three-byte forms
      '{8'hC0, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'hAF, 1'b0, 1'b1, 2'd1, 21'h00000, ErrOverlong,  21'h0, ErrOk},
      '{8'hE0, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b1, 2'd1, 21'h00000, ErrOverlong,  21'h0, ErrOk},
      // lowest surrogate
      '{8'hED, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'hA0, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b1, 2'd1, 21'h00000, ErrSurrogate, 21'h0, ErrOk},
      // one above the top scalar
      '{8'hF4, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h90, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h80, 1'b0, 1'b1, 2'd1, 21'h00000, ErrTooLarge,  21'h0, ErrOk},
      // broken sequence, then the byte again as a lead
      '{8'hE2, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h41, 1'b0, 1'b1, 2'd2, 21'h00000, ErrBadCont,   21'h41, ErrOk},
      '{8'hF0, 1'b1, 1'b1, 2'd1, 21'h00000, ErrTruncated, 21'h0, ErrOk},
      '{8'hE2, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'hF0, 1'b1, 1'b1, 2'd2, 21'h00000, ErrBadCont,   21'h0, ErrTruncated},
      // top scalar, end flag on the completing byte
      '{8'hF4, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'h8F, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'hBF, 1'b0, 1'b0, 2'd0, 21'h00000, ErrOk,        21'h0, ErrOk},
      '{8'hBF, 1'b1, 1'b1, 2'd1, 21'h10FFFF, ErrOk,       21'h0, ErrOk}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i]);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 58; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      while (stim_q.size() < RandomWords / Phases) add_sequence();
      while (stim_q.size() != 0) send_word(stim_q.pop_front());
    end
    in_valid <= 1'b0;

    // drain, then give stray results a chance to show
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Fed %0d byte words: directed rows, then four pacing phases of random text",
             words_sent);
    $display("Checked %0d result words, %0d of them error reports", results_seen,
             error_results);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/utf8_stream_decoder_top.sv
tb/tb_top.sv
